// ===== rtl/tsg_pkg.sv =====
`timescale 1ns / 1ps
package tsg_pkg;
    localparam int NOTE_SLOTS = 64;
    localparam int NS_AW = $clog2(NOTE_SLOTS);
    localparam int ENTRY_W = 40;
    localparam logic [15:0] BEAT_DIVIDEND = 16'd60000;

    localparam logic [2:0] CMD_PWM = 3'd0;
    localparam logic [2:0] CMD_MS = 3'd1;
    localparam logic [2:0] CMD_OFF = 3'd2;
    localparam logic [2:0] CMD_TONE = 3'd3;
    localparam logic [2:0] CMD_SONG = 3'd4;
    localparam logic [2:0] CMD_SWEEP = 3'd5;
    localparam logic [2:0] CMD_NOTE = 3'd6;

    localparam logic [1:0] ACT_TONE = 2'd0;
    localparam logic [1:0] ACT_SONG = 2'd1;
    localparam logic [1:0] ACT_SWEEP = 2'd2;

    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_LATCH = 4'd1;
    localparam logic [3:0] OP_SIMPLE = 4'd2;
    localparam logic [3:0] OP_DIV_START = 4'd3;
    localparam logic [3:0] OP_SONG_INIT = 4'd4;
    localparam logic [3:0] OP_SWEEP_INIT = 4'd5;
    localparam logic [3:0] OP_SONG_CHECK = 4'd6;
    localparam logic [3:0] OP_WRAP_OR_LOAD = 4'd7;
    localparam logic [3:0] OP_LOAD = 4'd8;

    localparam logic [1:0] RD_CUR = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_ZERO = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic       rd_en;
        logic [1:0] rd_sel;
    } tsg_cmd_t;

    typedef struct packed {
        logic is_song;
        logic is_sweep;
        logic song_expire;
        logic advance;
        logic next_zero;
        logic div_done;
    } tsg_stat_t;
endpackage

// ===== rtl/tsg_ram.sv =====
`timescale 1ns / 1ps
module tsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/tsg_div.sv =====
`timescale 1ns / 1ps
module tsg_div
    import tsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [16:0] shifted;
    logic [16:0] diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[15]};
        diff = shifted - {1'b0, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[16])
            begin
                rem_next = diff[15:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[15:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== rtl/tsg_ctrl.sv =====
`timescale 1ns / 1ps
module tsg_ctrl
    import tsg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  tsg_stat_t stat,
    output tsg_cmd_t  ctl,
    output logic      busy,
    output logic      done
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIVW = 3'd2;
    localparam logic [2:0] S_RCUR = 3'd3;
    localparam logic [2:0] S_RNEXT = 3'd4;
    localparam logic [2:0] S_RZERO = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl = '{op: OP_NONE, rd_en: 1'b0, rd_sel: RD_CUR};
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op = OP_LATCH;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_song || stat.is_sweep)
                begin
                    ctl.op = OP_DIV_START;
                    state_next = S_DIVW;
                end
                else
                begin
                    ctl.op = OP_SIMPLE;
                    if (stat.song_expire)
                    begin
                        ctl.rd_en = 1'b1;
                        ctl.rd_sel = RD_CUR;
                        state_next = S_RCUR;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    if (stat.is_song)
                    begin
                        ctl.op = OP_SONG_INIT;
                        ctl.rd_en = 1'b1;
                        ctl.rd_sel = RD_ZERO;
                        state_next = S_RZERO;
                    end
                    else
                    begin
                        ctl.op = OP_SWEEP_INIT;
                        state_next = S_OUT;
                    end
                end
            end
            S_RCUR:
            begin
                ctl.op = OP_SONG_CHECK;
                if (stat.advance)
                begin
                    ctl.rd_en = 1'b1;
                    ctl.rd_sel = RD_NEXT;
                    state_next = S_RNEXT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_RNEXT:
            begin
                ctl.op = OP_WRAP_OR_LOAD;
                if (stat.next_zero)
                begin
                    ctl.rd_en = 1'b1;
                    ctl.rd_sel = RD_ZERO;
                    state_next = S_RZERO;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_RZERO:
            begin
                ctl.op = OP_LOAD;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);
endmodule

// ===== rtl/tsg_dp.sv =====
`timescale 1ns / 1ps
module tsg_dp
    import tsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tsg_cmd_t    ctl,
    output tsg_stat_t   stat,
    input  logic [2:0]  cmd,
    input  logic [15:0] freq,
    input  logic [7:0]  level,
    input  logic [15:0] duration,
    input  logic [7:0]  tempo,
    input  logic [15:0] speed,
    input  logic        direction,
    input  logic [5:0]  note_slot,
    output logic [7:0]  duty,
    output logic        tick_enabled,
    output logic        timer_active
);
    logic [2:0]  cmd_reg;
    logic [15:0] freq_reg;
    logic [7:0]  level_reg;
    logic [15:0] dur_reg;
    logic [7:0]  tempo_reg;
    logic [15:0] speed_reg;
    logic        dir_reg;
    logic [5:0]  slot_reg;

    logic [15:0] pwm_count_reg, pwm_count_next;
    logic [14:0] half_reg, half_next;
    logic [7:0]  tone_reg, tone_next;
    logic [7:0]  duty_reg, duty_next;
    logic        pwm_en_reg, pwm_en_next;
    logic        run_reg, run_next;
    logic        rep_reg, rep_next;
    logic [1:0]  act_reg, act_next;
    logic [15:0] period_reg, period_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] beat_reg, beat_next;
    logic [NS_AW-1:0] pos_reg, pos_next;
    logic [15:0] spos_reg, spos_next;
    logic [15:0] stot_reg, stot_next;
    logic [15:0] sstart_reg, sstart_next;
    logic        sup_reg, sup_next;
    logic [7:0]  slevel_reg, slevel_next;

    logic [NOTE_SLOTS-1:0] valid_reg;
    logic                  rvalid_reg;
    logic [ENTRY_W-1:0]    ram_q;
    logic [ENTRY_W-1:0]    entry;
    logic [15:0] e_freq;
    logic [7:0]  e_level;
    logic [15:0] e_dur;
    logic [NS_AW-1:0] next_pos;
    logic [NS_AW-1:0] raddr;
    logic [NS_AW-1:0] waddr;
    logic        slot_ok;
    logic        we;

    logic [15:0] pwm_inc;
    logic [15:0] el_inc;
    logic        expire;
    logic [15:0] beat_inc;
    logic [15:0] spos_inc;
    logic [15:0] sweep_f;
    logic [7:0]  tempo1;
    logic [15:0] speed1;
    logic [15:0] dividend;
    logic [15:0] divisor;
    logic        div_done;
    logic [15:0] quotient;

    assign entry = rvalid_reg ? ram_q : '0;
    assign e_freq = entry[39:24];
    assign e_level = entry[23:16];
    assign e_dur = entry[15:0];
    assign next_pos = (pos_reg == NS_AW'(NOTE_SLOTS - 1)) ? '0 : pos_reg + 1'b1;
    assign slot_ok = (32'(slot_reg) < NOTE_SLOTS);
    assign waddr = NS_AW'(slot_reg);
    assign we = (ctl.op == OP_SIMPLE) && (cmd_reg == CMD_NOTE) && slot_ok;

    always_comb
    begin
        case (ctl.rd_sel)
            RD_CUR: raddr = pos_reg;
            RD_NEXT: raddr = next_pos;
            default: raddr = '0;
        endcase
    end

    assign tempo1 = (tempo_reg == 8'd0) ? 8'd1 : tempo_reg;
    assign speed1 = (speed_reg == 16'd0) ? 16'd1 : speed_reg;
    assign dividend = (cmd_reg == CMD_SONG) ? BEAT_DIVIDEND : dur_reg;
    assign divisor = (cmd_reg == CMD_SONG) ? {5'd0, tempo1, 3'd0} : speed1;

    assign pwm_inc = pwm_count_reg + 16'd1;
    assign el_inc = elapsed_reg + 16'd1;
    assign expire = run_reg && (el_inc >= period_reg);
    assign beat_inc = beat_reg + 16'd1;
    assign spos_inc = spos_reg + 16'd1;
    assign sweep_f = sup_reg ? (sstart_reg + spos_inc) : (sstart_reg - spos_inc);

    assign stat.is_song = (cmd_reg == CMD_SONG);
    assign stat.is_sweep = (cmd_reg == CMD_SWEEP);
    assign stat.song_expire = (cmd_reg == CMD_MS) && expire && (act_reg == ACT_SONG);
    assign stat.advance = (beat_inc >= e_dur);
    assign stat.next_zero = (e_freq == 16'd0);
    assign stat.div_done = div_done;

    tsg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.op == OP_DIV_START),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    tsg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NOTE_SLOTS)
    ) u_notes (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata ({freq_reg, level_reg, dur_reg}),
        .re    (ctl.rd_en),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        pwm_count_next = pwm_count_reg;
        half_next = half_reg;
        tone_next = tone_reg;
        duty_next = duty_reg;
        pwm_en_next = pwm_en_reg;
        run_next = run_reg;
        rep_next = rep_reg;
        act_next = act_reg;
        period_next = period_reg;
        elapsed_next = elapsed_reg;
        beat_next = beat_reg;
        pos_next = pos_reg;
        spos_next = spos_reg;
        stot_next = stot_reg;
        sstart_next = sstart_reg;
        sup_next = sup_reg;
        slevel_next = slevel_reg;
        case (ctl.op)
            OP_SIMPLE:
            begin
                case (cmd_reg)
                    CMD_PWM:
                    begin
                        if (pwm_en_reg)
                        begin
                            pwm_count_next = pwm_inc;
                            if (pwm_inc >= {1'b0, half_reg})
                            begin
                                pwm_count_next = '0;
                                duty_next = (duty_reg == 8'd0) ? tone_reg : 8'd0;
                            end
                        end
                    end
                    CMD_MS:
                    begin
                        if (run_reg)
                        begin
                            elapsed_next = el_inc;
                            if (expire)
                            begin
                                if (rep_reg)
                                begin
                                    elapsed_next = '0;
                                end
                                else
                                begin
                                    run_next = 1'b0;
                                end
                                if (act_reg == ACT_TONE)
                                begin
                                    duty_next = '0;
                                    pwm_en_next = 1'b0;
                                    run_next = 1'b0;
                                end
                                else if (act_reg != ACT_SONG && spos_reg < stot_reg)
                                begin
                                    spos_next = spos_inc;
                                    half_next = sweep_f[15:1];
                                    tone_next = slevel_reg;
                                    if (spos_inc == stot_reg)
                                    begin
                                        duty_next = '0;
                                        pwm_en_next = 1'b0;
                                        run_next = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    CMD_OFF:
                    begin
                        run_next = 1'b0;
                        pwm_en_next = 1'b0;
                        duty_next = '0;
                    end
                    CMD_TONE:
                    begin
                        pwm_en_next = 1'b1;
                        half_next = freq_reg[15:1];
                        tone_next = level_reg;
                        duty_next = level_reg;
                        run_next = 1'b1;
                        rep_next = 1'b0;
                        period_next = dur_reg;
                        elapsed_next = '0;
                        act_next = ACT_TONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_SONG_INIT:
            begin
                pwm_en_next = 1'b1;
                pwm_count_next = '0;
                duty_next = '0;
                run_next = 1'b1;
                rep_next = 1'b1;
                period_next = quotient;
                elapsed_next = '0;
                act_next = ACT_SONG;
                beat_next = '0;
                pos_next = '0;
            end
            OP_SWEEP_INIT:
            begin
                pwm_en_next = 1'b1;
                spos_next = '0;
                stot_next = quotient;
                sstart_next = freq_reg;
                sup_next = dir_reg;
                slevel_next = level_reg;
                half_next = freq_reg[15:1];
                tone_next = level_reg;
                duty_next = level_reg;
                run_next = 1'b1;
                rep_next = 1'b1;
                period_next = speed1;
                elapsed_next = '0;
                act_next = ACT_SWEEP;
            end
            OP_SONG_CHECK:
            begin
                if (stat.advance)
                begin
                    beat_next = '0;
                    pos_next = next_pos;
                end
                else
                begin
                    beat_next = beat_inc;
                end
            end
            OP_WRAP_OR_LOAD:
            begin
                if (stat.next_zero)
                begin
                    pos_next = '0;
                end
                else
                begin
                    half_next = e_freq[15:1];
                    tone_next = e_level;
                    duty_next = e_level;
                end
            end
            OP_LOAD:
            begin
                half_next = e_freq[15:1];
                tone_next = e_level;
                duty_next = e_level;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_count_reg <= '0;
            half_reg <= '0;
            tone_reg <= '0;
            duty_reg <= '0;
            pwm_en_reg <= 1'b0;
            run_reg <= 1'b0;
            rep_reg <= 1'b0;
            act_reg <= ACT_TONE;
            period_reg <= '0;
            elapsed_reg <= '0;
            beat_reg <= '0;
            pos_reg <= '0;
            spos_reg <= '0;
            stot_reg <= '0;
            sstart_reg <= '0;
            sup_reg <= 1'b0;
            slevel_reg <= '0;
            valid_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            pwm_count_reg <= pwm_count_next;
            half_reg <= half_next;
            tone_reg <= tone_next;
            duty_reg <= duty_next;
            pwm_en_reg <= pwm_en_next;
            run_reg <= run_next;
            rep_reg <= rep_next;
            act_reg <= act_next;
            period_reg <= period_next;
            elapsed_reg <= elapsed_next;
            beat_reg <= beat_next;
            pos_reg <= pos_next;
            spos_reg <= spos_next;
            stot_reg <= stot_next;
            sstart_reg <= sstart_next;
            sup_reg <= sup_next;
            slevel_reg <= slevel_next;
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LATCH)
        begin
            cmd_reg <= cmd;
            freq_reg <= freq;
            level_reg <= level;
            dur_reg <= duration;
            tempo_reg <= tempo;
            speed_reg <= speed;
            dir_reg <= direction;
            slot_reg <= note_slot;
        end
    end

    assign duty = duty_reg;
    assign tick_enabled = pwm_en_reg;
    assign timer_active = run_reg;
endmodule

// ===== rtl/pwm_tone_song_sweep_generator_unit.sv =====
// Each word passes from idle through an execute state to the done state; a ms tick that steps a
// song also reads the note table, for the current note, the next one and, on a wrap, slot zero.
// Sweep start and song start also wait on the shared bit-serial divider and, for a song, one
// note table read. A new word is taken the cycle after done.
// The receiver cannot stall: done is high for exactly one cycle with the results.
// Asynchronous active-low reset clears the control, timer and tone state; the note table reads as zero until written.
`timescale 1ns / 1ps
module pwm_tone_song_sweep_generator_unit
    import tsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [15:0] freq,
    input  logic [7:0]  level,
    input  logic [15:0] duration,
    input  logic [7:0]  tempo,
    input  logic [15:0] speed,
    input  logic        direction,
    input  logic [5:0]  note_slot,
    output logic        done,
    output logic [7:0]  duty,
    output logic        tick_enabled,
    output logic        timer_active
);
    tsg_cmd_t  ctl;
    tsg_stat_t stat;

    tsg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    tsg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cmd          (cmd),
        .freq         (freq),
        .level        (level),
        .duration     (duration),
        .tempo        (tempo),
        .speed        (speed),
        .direction    (direction),
        .note_slot    (note_slot),
        .duty         (duty),
        .tick_enabled (tick_enabled),
        .timer_active (timer_active)
    );
endmodule

// ===== tb/sv/pwm_tone_song_sweep_generator_unit_test.sv =====
`timescale 1ns / 1ps
module pwm_tone_song_sweep_generator_unit_test;
    import tsg_pkg::*;

    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] freq;
        logic [7:0]  level;
        logic [15:0] duration;
        logic [7:0]  tempo;
        logic [15:0] speed;
        logic        direction;
        logic [5:0]  note_slot;
    } word_t;

    typedef struct {
        logic [7:0] duty;
        logic       tick_en;
        logic       timer_on;
    } status_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  cmd;
    logic [15:0] freq;
    logic [7:0]  level;
    logic [15:0] duration;
    logic [7:0]  tempo;
    logic [15:0] speed;
    logic        direction;
    logic [5:0]  note_slot;
    logic        done;
    logic [7:0]  duty;
    logic        tick_enabled;
    logic        timer_active;

    pwm_tone_song_sweep_generator_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .freq(freq), .level(level), .duration(duration), .tempo(tempo),
        .speed(speed), .direction(direction), .note_slot(note_slot),
        .done(done), .duty(duty), .tick_enabled(tick_enabled),
        .timer_active(timer_active)
    );

    word_t   pending_words[$];
    status_t expected_status[$];
    int      fail_count = 0;
    int      sender_idle_pct = 10;
    bit      hold_sender = 0;
    longint  cycle_count = 0;

    logic [15:0] m_pwm_count, m_half_period, m_period, m_elapsed, m_beat;
    logic [15:0] m_sweep_pos, m_sweep_total, m_sweep_start;
    logic [7:0]  m_tone_level, m_duty, m_sweep_level;
    logic        m_pwm_on, m_timer_on, m_repeat, m_sweep_up;
    logic [1:0]  m_action;
    logic [5:0]  m_note_pos;
    logic [15:0] nt_freq[NOTE_SLOTS];
    logic [7:0]  nt_level[NOTE_SLOTS];
    logic [15:0] nt_dur[NOTE_SLOTS];

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic model_reset();
        {m_pwm_count, m_half_period, m_period, m_elapsed, m_beat} = '0;
        {m_sweep_pos, m_sweep_total, m_sweep_start} = '0;
        {m_tone_level, m_duty, m_sweep_level} = '0;
        {m_pwm_on, m_timer_on, m_repeat, m_sweep_up, m_action, m_note_pos} = '0;
        for (int i = 0; i < NOTE_SLOTS; i++)
        begin
            nt_freq[i] = '0;
            nt_level[i] = '0;
            nt_dur[i] = '0;
        end
    endtask

    task automatic load_note_into_pwm(input logic [5:0] idx);
        m_half_period = nt_freq[idx] >> 1;
        m_tone_level = nt_level[idx];
        m_duty = m_tone_level;
    endtask

    task automatic predict_status(input word_t w);
        logic [15:0] f;
        logic [15:0] spd;
        logic [7:0]  tmp;
        status_t     s;
        case (w.cmd)
            CMD_PWM:
                if (m_pwm_on)
                begin
                    m_pwm_count = m_pwm_count + 16'd1;
                    if (m_pwm_count >= m_half_period)
                    begin
                        m_pwm_count = '0;
                        m_duty = (m_duty == 0) ? m_tone_level : 8'd0;
                    end
                end
            CMD_MS:
                if (m_timer_on)
                begin
                    m_elapsed = m_elapsed + 16'd1;
                    if (m_elapsed >= m_period)
                    begin
                        if (m_repeat)
                            m_elapsed = '0;
                        else
                            m_timer_on = 0;
                        if (m_action == ACT_TONE)
                        begin
                            m_pwm_on = 0;
                            m_duty = '0;
                            m_timer_on = 0;
                        end
                        else if (m_action == ACT_SONG)
                        begin
                            m_beat = m_beat + 16'd1;
                            if (m_beat >= nt_dur[m_note_pos])
                            begin
                                m_beat = '0;
                                m_note_pos = m_note_pos + 6'd1;
                                if (nt_freq[m_note_pos] == 0)
                                    m_note_pos = '0;
                                load_note_into_pwm(m_note_pos);
                            end
                        end
                        else if (m_sweep_pos < m_sweep_total)
                        begin
                            m_sweep_pos = m_sweep_pos + 16'd1;
                            f = m_sweep_up ? m_sweep_start + m_sweep_pos
                                           : m_sweep_start - m_sweep_pos;
                            m_half_period = f >> 1;
                            m_tone_level = m_sweep_level;
                            if (m_sweep_pos == m_sweep_total)
                            begin
                                m_pwm_on = 0;
                                m_duty = '0;
                                m_timer_on = 0;
                            end
                        end
                    end
                end
            CMD_OFF:
            begin
                m_timer_on = 0;
                m_pwm_on = 0;
                m_duty = '0;
            end
            CMD_TONE:
            begin
                m_pwm_on = 1;
                m_half_period = w.freq >> 1;
                m_tone_level = w.level;
                m_duty = w.level;
                m_timer_on = 1;
                m_repeat = 0;
                m_period = w.duration;
                m_elapsed = '0;
                m_action = ACT_TONE;
            end
            CMD_SONG:
            begin
                tmp = (w.tempo == 0) ? 8'd1 : w.tempo;
                m_pwm_on = 1;
                m_pwm_count = '0;
                load_note_into_pwm(6'd0);
                m_timer_on = 1;
                m_repeat = 1;
                m_period = 16'(32'd60000 / (32'(tmp) * 32'd8));
                m_elapsed = '0;
                m_action = ACT_SONG;
                m_beat = '0;
                m_note_pos = '0;
            end
            CMD_SWEEP:
            begin
                spd = (w.speed == 0) ? 16'd1 : w.speed;
                m_pwm_on = 1;
                m_sweep_pos = '0;
                m_sweep_total = w.duration / spd;
                m_sweep_start = w.freq;
                m_sweep_up = w.direction;
                m_sweep_level = w.level;
                m_half_period = w.freq >> 1;
                m_tone_level = w.level;
                m_duty = w.level;
                m_timer_on = 1;
                m_repeat = 1;
                m_period = spd;
                m_elapsed = '0;
                m_action = ACT_SWEEP;
            end
            CMD_NOTE:
            begin
                nt_freq[w.note_slot] = w.freq;
                nt_level[w.note_slot] = w.level;
                nt_dur[w.note_slot] = w.duration;
            end
            default:
                ;
        endcase
        s.duty = m_duty;
        s.tick_en = m_pwm_on;
        s.timer_on = m_timer_on;
        expected_status.push_back(s);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d",
                 what, got, want, cycle_count);
        fail_count++;
    endtask

    // Records whether the word on the bus was taken at the last rising edge.
    logic accepted_at_edge;
    always @(posedge clk)
    begin
        accepted_at_edge <= start && !busy;
    end

    always @(negedge clk)
    begin
        word_t w;
        if (!rst_n)
        begin
            start <= 0;
            cmd <= '0;
            freq <= '0;
            level <= '0;
            duration <= '0;
            tempo <= '0;
            speed <= '0;
            direction <= 0;
            note_slot <= '0;
        end
        else if (!start || accepted_at_edge)
        begin
            if (pending_words.size() > 0 && !hold_sender &&
                $urandom_range(99) >= sender_idle_pct)
            begin
                w = pending_words.pop_front();
                cmd <= w.cmd;
                freq <= w.freq;
                level <= w.level;
                duration <= w.duration;
                tempo <= w.tempo;
                speed <= w.speed;
                direction <= w.direction;
                note_slot <= w.note_slot;
                predict_status(w);
                start <= 1;
            end
            else
            begin
                start <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        status_t e;
        if (rst_n && done)
        begin
            if (expected_status.size() == 0)
            begin
                report_mismatch("unexpected status word", 16'd1, 16'd0);
            end
            else
            begin
                e = expected_status.pop_front();
                if (duty !== e.duty)
                    report_mismatch("duty", duty, e.duty);
                if (tick_enabled !== e.tick_en)
                    report_mismatch("tick_enabled", tick_enabled, e.tick_en);
                if (timer_active !== e.timer_on)
                    report_mismatch("timer_active", timer_active, e.timer_on);
            end
        end
    end

    function automatic word_t rand_word(input logic [2:0] c);
        word_t w;
        w.cmd = c;
        w.freq = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        w.level = 8'($urandom);
        w.duration = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6));
        w.tempo = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(255, 230));
        w.speed = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(3));
        w.direction = 1'($urandom);
        w.note_slot = ($urandom_range(2) == 0) ? 6'($urandom) : 6'($urandom_range(4));
        return w;
    endfunction

    function automatic word_t make_word(input logic [2:0] c, input logic [15:0] f,
                                        input logic [7:0] l, input logic [15:0] d,
                                        input logic [7:0] t, input logic [15:0] s,
                                        input logic dir, input logic [5:0] slot);
        word_t w;
        w = '{c, f, l, d, t, s, dir, slot};
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || start || expected_status.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 30)
                pending_words.push_back(rand_word(CMD_PWM));
            else if (r < 65)
                pending_words.push_back(rand_word(CMD_MS));
            else if (r < 68)
                pending_words.push_back(rand_word(CMD_OFF));
            else if (r < 74)
                pending_words.push_back(rand_word(CMD_TONE));
            else if (r < 80)
                pending_words.push_back(rand_word(CMD_SONG));
            else if (r < 86)
                pending_words.push_back(rand_word(CMD_SWEEP));
            else if (r < 98)
                pending_words.push_back(rand_word(CMD_NOTE));
            else
                pending_words.push_back(rand_word(3'd7));
        end
    endtask

    initial
    begin
        rst_n = 0;
        model_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        pending_words.push_back(make_word(CMD_SONG, 0, 0, 0, 8'd0, 0, 0, 0));
        pending_words.push_back(make_word(CMD_MS, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(CMD_NOTE, 16'hFFFF, 8'hFF, 16'd1, 0, 0, 0, 6'd0));
        pending_words.push_back(make_word(CMD_NOTE, 16'd4, 8'h01, 16'd1, 0, 0, 0, 6'd1));
        pending_words.push_back(make_word(CMD_NOTE, 16'd6, 8'h80, 16'd2, 0, 0, 0, 6'd63));
        pending_words.push_back(make_word(CMD_SONG, 0, 0, 0, 8'd255, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            pending_words.push_back(make_word(CMD_MS, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(CMD_PWM, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(CMD_TONE, 16'd3, 8'hAA, 16'd0, 0, 0, 0, 0));
        pending_words.push_back(make_word(CMD_PWM, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(CMD_MS, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(CMD_SWEEP, 16'd1, 8'h55, 16'd2, 0, 16'd0, 0, 0));
        pending_words.push_back(make_word(CMD_MS, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(CMD_MS, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(CMD_SWEEP, 16'hFFFF, 8'h7F, 16'd0, 0, 16'hFFFF,
                                          1, 6'h3F));
        pending_words.push_back(make_word(CMD_MS, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(3'd7, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(CMD_OFF, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        sender_idle_pct = 10;
        random_phase(250);
        wait_drained();
        hold_sender = 1;
        sender_idle_pct = 66;
        random_phase(250);
        repeat (20) @(posedge clk);
        hold_sender = 0;
        wait_drained();
        sender_idle_pct = 0;
        random_phase(250);
        wait_drained();
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
